FILE: hdl/fra_pkg.sv
package fra_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned FENCE_W = 48;
   localparam int unsigned ALIGN_W = 5;

   localparam logic [ADDR_W-1:0] HEAP_RESET = 32'd1048576;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_PLACE,
      ST_RETIRE,
      ST_PUSH,
      ST_TAG,
      ST_DRAIN
   } fra_state_type;

   // one live range
   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [ADDR_W-1:0]  size;
      logic [FENCE_W-1:0] fence;
      logic               fenced;
   } fra_entry_type;

   // per-cell controls
   typedef struct packed {
      logic shift;
      logic load;
      logic tag;
   } fra_cell_ctrl_type;

endpackage

FILE: hdl/fra_cell.sv
module fra_cell
   import fra_pkg::*;
(
   input  logic               clock,
   input  fra_cell_ctrl_type  ctrl,
   input  fra_entry_type      neighbor,
   input  logic [ADDR_W-1:0]  load_start,
   input  logic [ADDR_W-1:0]  load_size,
   input  logic [FENCE_W-1:0] tag_fence,
   output fra_entry_type      entry
);

   fra_entry_type entry_ff;
   fra_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = neighbor;
      end else if (ctrl.load) begin
         entry_in.start  = load_start;
         entry_in.size   = load_size;
         entry_in.fence  = '0;
         entry_in.fenced = 1'b0;
      end else if (ctrl.tag && !entry_ff.fenced) begin
         entry_in.fence  = tag_fence;
         entry_in.fenced = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: hdl/fenced_ring_allocator.sv
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// request   | req_command .. req_completed_fence      | transfer when start & !busy
// response  | rsp_status, rsp_range_start/bytes,      | rsp_valid high for one cycle,
//           | rsp_ranges_remain                       | always taken
// config    | csr_heap_bytes                          | transfer when csr_valid & csr_ready
//
// allocate runs align, place, overlap check (retiring done front ranges) and push;
//   an empty ring goes from align to push, a bad size answers from align. frame
//   complete answers from tag when it tags, else drains done ranges from the front:
//   the range queue pops one entry a cycle by shifting the whole row of cells.
// the response strobe comes in the cycle after the last state, when busy is already low.
// reset clears fsm and entry count, sets heap size to HEAP_RESET; range cells need none.
// the response side cannot stall.
module fenced_ring_allocator
   import fra_pkg::*;
#(
   parameter int unsigned MAX_RANGES = 16
)
(
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [ADDR_W-1:0]  req_alloc_size,
   input  logic [ALIGN_W-1:0] req_align_log2,
   input  logic [FENCE_W-1:0] req_frame_fence,
   input  logic [FENCE_W-1:0] req_completed_fence,
   // response
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [ADDR_W-1:0]  rsp_range_start,
   output logic [ADDR_W-1:0]  rsp_range_bytes,
   output logic               rsp_ranges_remain,
   // config
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ADDR_W-1:0]  csr_heap_bytes
);

   localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

   // fsm and control state
   fra_state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] heap_ff;

   // latched request
   logic               cmd_ff;
   logic [ADDR_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [FENCE_W-1:0] fence_ff;
   logic [FENCE_W-1:0] done_ff;

   // placement datapath
   logic [ADDR_W+1:0] aligned_ff, aligned_in;   // aligned end of newest range, no wrap
   logic [ADDR_W-1:0] start_ff, start_in;       // start of the range being placed
   logic [ADDR_W:0]   end_ff, end_in;           // start + size of that range
   logic [ADDR_W:0]   tail_end_ff, tail_end_in; // start + size of newest live range

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_start_ff, rsp_start_in;
   logic [ADDR_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic              rsp_remain_ff, rsp_remain_in;

   // cell row
   fra_cell_ctrl_type cell_ctrl [MAX_RANGES];
   fra_entry_type     cell_out  [MAX_RANGES];
   logic [MAX_RANGES-1:0] occupied;

   logic               take;
   logic               bad_size;
   logic               front_done;
   logic               overlap;
   logic               any_untagged;
   logic               tag_step;
   logic               pop;
   logic               push;
   logic [ADDR_W+1:0]  align_mask;
   logic [ADDR_W+2:0]  place_sum;
   logic               wrap;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign take      = start && !busy;

   // ---------------------------------------------------------------------
   // row of range cells, oldest range in cell 0; a pop shifts toward cell 0
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      fra_entry_type nb;
      if (i == MAX_RANGES - 1) begin : g_last
         assign nb = cell_out[i];
      end else begin : g_mid
         assign nb = cell_out[i+1];
      end

      assign occupied[i]        = (count_ff > CNT_W'(i));
      assign cell_ctrl[i].shift = pop;
      assign cell_ctrl[i].load  = push && (count_ff == CNT_W'(i));
      assign cell_ctrl[i].tag   = tag_step && occupied[i];

      fra_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .neighbor   (nb),
         .load_start (start_ff),
         .load_size  (size_ff),
         .tag_fence  (fence_ff),
         .entry      (cell_out[i])
      );
   end

   // untagged entries always form the newest run, so tagging every one of them
   // is the same as walking back from the newest
   always_comb begin
      any_untagged = 1'b0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         any_untagged = any_untagged | (occupied[i] & ~cell_out[i].fenced);
      end
   end

   // front range status
   assign front_done = cell_out[0].fenced && (cell_out[0].fence <= done_ff);
   assign overlap    = (count_ff != '0) && (start_ff <= cell_out[0].start) &&
                       (end_ff > {1'b0, cell_out[0].start});

   // size check and alignment
   assign bad_size   = (size_ff == '0) || (size_ff > heap_ff);
   assign align_mask = ~({(ADDR_W+2){1'b1}} << align_ff);
   assign aligned_in = ({1'b0, tail_end_ff} + align_mask) & ~align_mask;

   // wrap to 0 when the range would reach the heap end
   assign place_sum  = {1'b0, aligned_ff} + {3'b000, size_ff};
   assign wrap       = place_sum >= {3'b000, heap_ff};

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_command == CMD_FRAME) ? ST_TAG : ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (bad_size) begin
               state_in = ST_IDLE;
            end else if (count_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_RETIRE;
         ST_RETIRE: begin
            if (overlap) begin
               state_in = front_done ? ST_RETIRE : ST_IDLE;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: state_in = ST_IDLE;
         ST_TAG: state_in = any_untagged ? ST_IDLE : ST_DRAIN;
         ST_DRAIN: begin
            if ((count_ff == '0) || !front_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs and datapath controls
   // ---------------------------------------------------------------------
   always_comb begin
      pop           = 1'b0;
      push          = 1'b0;
      tag_step      = 1'b0;
      count_in      = count_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      tail_end_in   = tail_end_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_start_in  = '0;
      rsp_bytes_in  = '0;
      rsp_remain_in = 1'b0;
      case (state_ff)
         ST_IDLE: ;
         ST_ALIGN: begin
            if (bad_size) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BAD_SIZE;
            end else begin
               // empty ring places at 0
               start_in = '0;
               end_in   = {1'b0, size_ff};
            end
         end
         ST_PLACE: begin
            if (wrap) begin
               start_in = '0;
               end_in   = {1'b0, size_ff};
            end else begin
               start_in = aligned_ff[ADDR_W-1:0];
               end_in   = place_sum[ADDR_W:0];
            end
         end
         ST_RETIRE: begin
            if (overlap) begin
               if (front_done) begin
                  pop      = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_ROOM;
               end
            end
         end
         ST_PUSH: begin
            rsp_valid_in = 1'b1;
            if (count_ff >= CNT_W'(MAX_RANGES)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               push         = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               tail_end_in  = end_ff;
               rsp_start_in = start_ff;
               rsp_bytes_in = size_ff;
            end
         end
         ST_TAG: begin
            tag_step = 1'b1;
            if (any_untagged) begin
               rsp_valid_in  = 1'b1;
               rsp_remain_in = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
            end else if (front_done) begin
               pop      = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_remain_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         heap_ff      <= HEAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            heap_ff <= csr_heap_bytes;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff   <= req_command;
         size_ff  <= req_alloc_size;
         align_ff <= req_align_log2;
         fence_ff <= req_frame_fence;
         done_ff  <= req_completed_fence;
      end
      if (state_ff == ST_ALIGN) begin
         aligned_ff <= aligned_in;
      end
      start_ff      <= start_in;
      end_ff        <= end_in;
      tail_end_ff   <= tail_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      // a frame-complete result carries the remain flag, an allocate never does
      rsp_remain_ff <= rsp_remain_in & (cmd_ff == CMD_FRAME);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_range_start   = rsp_start_ff;
   assign rsp_range_bytes   = rsp_bytes_ff;
   assign rsp_ranges_remain = rsp_remain_ff;

endmodule

FILE: hdl/fra_checker.sv
module fra_checker
   import fra_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_status,
   input logic [ADDR_W-1:0] rsp_range_start,
   input logic [ADDR_W-1:0] rsp_range_bytes,
   input logic              rsp_ranges_remain,
   input logic              csr_ready
);

   // an accepted command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // a result closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a command in work");

   // refusals carry no range
   a_refuse_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_range_start == '0 && rsp_range_bytes == '0 && !rsp_ranges_remain))
      else $error("refused result carries range data");

   // remain flag only on a frame-complete result
   a_remain_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ranges_remain) |-> (rsp_range_bytes == '0))
      else $error("remain flag on an allocate result");

   // configuration closed while a command is in work
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("config port open while busy");

endmodule

bind fenced_ring_allocator fra_checker u_fra_checker (.*);

FILE: test/tb_fenced_ring_allocator.sv
`timescale 1ns / 100ps

module tb_fenced_ring_allocator;
   import fra_pkg::*;

   localparam int unsigned RING_DEPTH   = 16;
   // cycles with no transfer of any kind before the run is called hung
   localparam int unsigned QUIET_LIMIT  = 2000;
   // settle time after the last response, well past the longest item
   localparam int unsigned DRAIN_CYCLES = 40;
   // directed fill size, small enough that sixteen ranges fit the reset heap
   localparam logic [ADDR_W-1:0] FILL_BYTES = 32'd4096;
   localparam logic [FENCE_W-1:0] FENCE_MAX = '1;

   // one response as the ring should give it
   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] bytes;
      logic              remain;
   } ring_reply_type;

   // mirror of the range fifo plus the queue of replies still owed by the block
   class heap_ring_scoreboard #(int unsigned DEPTH = 16);
      logic [ADDR_W-1:0]  heap_limit;
      logic [ADDR_W-1:0]  rng_start [DEPTH];
      logic [ADDR_W-1:0]  rng_bytes [DEPTH];
      logic [FENCE_W-1:0] rng_fence [DEPTH];
      bit                 rng_tagged [DEPTH];
      int unsigned        oldest;
      int unsigned        live;
      ring_reply_type     expected_replies [$];
      int unsigned        mismatches;

      function new();
         heap_limit = HEAP_RESET;
         oldest     = 0;
         live       = 0;
         mismatches = 0;
      endfunction

      function int unsigned slot(int unsigned k);
         return (oldest + k) % DEPTH;
      endfunction

      function bit oldest_done(logic [FENCE_W-1:0] done_fence);
         return rng_tagged[oldest] && rng_fence[oldest] <= done_fence;
      endfunction

      function void retire_oldest();
         oldest = (oldest + 1) % DEPTH;
         live--;
      endfunction

      // works out the reply to one accepted command and updates the ring
      function void note_command(logic cmd, logic [ADDR_W-1:0] size,
                                 logic [ALIGN_W-1:0] align,
                                 logic [FENCE_W-1:0] tag_fence,
                                 logic [FENCE_W-1:0] done_fence);
         ring_reply_type reply;
         int unsigned k;
         int unsigned p;
         logic [63:0] mask;
         logic [63:0] place;
         bit          blocked;
         reply.status = STATUS_OK;
         reply.start  = '0;
         reply.bytes  = '0;
         reply.remain = 1'b0;
         if (cmd == CMD_FRAME) begin
            // tag the untagged tail, newest first
            k = live;
            while (k > 0 && !rng_tagged[slot(k - 1)]) begin
               p = slot(k - 1);
               rng_tagged[p] = 1'b1;
               rng_fence[p]  = tag_fence;
               reply.remain  = 1'b1;
               k--;
            end
            if (!reply.remain) begin
               while (live > 0 && oldest_done(done_fence))
                  retire_oldest();
               reply.remain = (live > 0);
            end
         end else if (size == '0 || size > heap_limit) begin
            reply.status = STATUS_BAD_SIZE;
         end else begin
            place   = '0;
            blocked = 1'b0;
            if (live > 0) begin
               p     = slot(live - 1);
               mask  = (64'd1 << align) - 64'd1;
               place = (64'(rng_start[p]) + 64'(rng_bytes[p]) + mask) & ~mask;
               if (place + 64'(size) >= 64'(heap_limit))
                  place = '0;
               while (live > 0 && !blocked && place <= 64'(rng_start[oldest])
                      && place + 64'(size) > 64'(rng_start[oldest])) begin
                  if (oldest_done(done_fence))
                     retire_oldest();
                  else
                     blocked = 1'b1;
               end
            end
            if (blocked) begin
               reply.status = STATUS_NO_ROOM;
            end else if (live >= DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               p = slot(live);
               rng_start[p]  = place[ADDR_W-1:0];
               rng_bytes[p]  = size;
               rng_fence[p]  = '0;
               rng_tagged[p] = 1'b0;
               live++;
               reply.start = place[ADDR_W-1:0];
               reply.bytes = size;
            end
         end
         expected_replies.push_back(reply);
      endfunction

      task report(string what);
         // keep the log short when the block is badly off
         if (mismatches < 100)
            $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_reply(logic [1:0] got_status, logic [ADDR_W-1:0] got_start,
                       logic [ADDR_W-1:0] got_bytes, logic got_remain);
         ring_reply_type want;
         if (expected_replies.size() == 0) begin
            report("response with no command outstanding");
         end else begin
            want = expected_replies[0];
            expected_replies.delete(0);
            if (got_status !== want.status)
               report($sformatf("status got %0d want %0d", got_status, want.status));
            if (got_start !== want.start)
               report($sformatf("range_start got %0h want %0h", got_start, want.start));
            if (got_bytes !== want.bytes)
               report($sformatf("range_bytes got %0h want %0h", got_bytes, want.bytes));
            if (got_remain !== want.remain)
               report($sformatf("ranges_remain got %0b want %0b", got_remain, want.remain));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [ADDR_W-1:0]  req_alloc_size;
   logic [ALIGN_W-1:0] req_align_log2;
   logic [FENCE_W-1:0] req_frame_fence;
   logic [FENCE_W-1:0] req_completed_fence;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [ADDR_W-1:0]  rsp_range_start;
   logic [ADDR_W-1:0]  rsp_range_bytes;
   logic               rsp_ranges_remain;
   logic               csr_valid;
   logic               csr_ready;
   logic [ADDR_W-1:0]  csr_heap_bytes;

   heap_ring_scoreboard #(RING_DEPTH) sb;

   int unsigned        items_sent;
   int unsigned        calm_left;
   int unsigned        quiet_cycles;
   // fence of the newest frame in the well-formed sequences
   logic [FENCE_W-1:0] frame_tag;

   fenced_ring_allocator #(
      .MAX_RANGES (RING_DEPTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_alloc_size      (req_alloc_size),
      .req_align_log2      (req_align_log2),
      .req_frame_fence     (req_frame_fence),
      .req_completed_fence (req_completed_fence),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_range_start     (rsp_range_start),
      .rsp_range_bytes     (rsp_range_bytes),
      .rsp_ranges_remain   (rsp_ranges_remain),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_heap_bytes      (csr_heap_bytes)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // everything is sampled at the rising edge, inputs only move on the falling one
   always @(posedge clock) begin
      if (!reset) begin
         // response strobe, always taken
         if (rsp_valid)
            sb.check_reply(rsp_status, rsp_range_start, rsp_range_bytes, rsp_ranges_remain);
         // command transfer
         if (start && !busy)
            sb.note_command(req_command, req_alloc_size, req_align_log2,
                            req_frame_fence, req_completed_fence);
         // heap size write
         if (csr_valid && csr_ready)
            sb.heap_limit = csr_heap_bytes;
      end
   end

   // watchdog: any transfer resets the count of quiet cycles
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // sender idle time: mostly none, some short, a few long, and calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 110) return 0;
      if (r < 170) return $urandom_range(1, 3);
      if (r < 194) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FENCE_W-1:0] rand_fence();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[FENCE_W-1:0];
   endfunction

   // mostly legal alignments, now and then the oversized ones
   function automatic logic [ALIGN_W-1:0] pick_align();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return '0;
      if (r < 90) return ALIGN_W'($urandom_range(0, 16));
      if (r < 97) return ALIGN_W'(16);
      return ALIGN_W'($urandom_range(17, 31));
   endfunction

   // sizes scaled to the heap so that the ring wraps and fills
   function automatic logic [ADDR_W-1:0] pick_size(logic [ADDR_W-1:0] heap);
      longint unsigned h;
      longint unsigned top;
      longint unsigned draw;
      int unsigned     r;
      h    = heap;
      draw = $urandom;
      r    = $urandom_range(0, 99);
      if (h == 0) return ADDR_W'(draw % 64);
      if (r < 55) begin
         top = h / $urandom_range(2, 24);
         if (top == 0) top = 1;
         return ADDR_W'(1 + draw % top);
      end
      if (r < 70) return ADDR_W'(1 + draw % ((h < 16) ? h : 16));
      if (r < 80) return ADDR_W'(h - draw % ((h < 64) ? h : 64));
      if (r < 85) return heap;
      if (r < 90) return '0;
      if (r < 95) return (heap == '1) ? heap : heap + 1'b1;
      return ADDR_W'(draw);
   endfunction

   // presents one command and returns at the falling edge after its transfer;
   // start stays high so a following command can go straight on
   task automatic send_request(logic cmd, logic [ADDR_W-1:0] size,
                               logic [ALIGN_W-1:0] align,
                               logic [FENCE_W-1:0] tag_fence,
                               logic [FENCE_W-1:0] done_fence);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start               = 1'b1;
      req_command         = cmd;
      req_alloc_size      = size;
      req_align_log2      = align;
      req_frame_fence     = tag_fence;
      req_completed_fence = done_fence;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // new heap size once the block is idle, then frames of allocations with
   // fences completing a little behind, mixed with unstructured commands
   task automatic run_phase(logic [ADDR_W-1:0] heap, int unsigned count);
      int unsigned        phase_end;
      int unsigned        n;
      int unsigned        r;
      int unsigned        lag;
      logic [FENCE_W-1:0] done;
      start = 1'b0;
      while (sb.expected_replies.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_valid      = 1'b1;
      csr_heap_bytes = heap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;

      frame_tag = rand_fence();
      phase_end = items_sent + count;
      while (items_sent < phase_end) begin
         if ($urandom_range(0, 99) < 80) begin
            // one frame: a few allocations, then its frame complete
            n   = $urandom_range(1, 6);
            r   = $urandom_range(0, 9);
            lag = (r < 3) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 5;
            done = (frame_tag > lag) ? frame_tag - lag : '0;
            repeat (n)
               send_request(CMD_ALLOC, pick_size(heap), pick_align(), rand_fence(), done);
            frame_tag = frame_tag + 1'b1;
            done = (frame_tag > lag) ? frame_tag - lag : '0;
            send_request(CMD_FRAME, $urandom, pick_align(), frame_tag, done);
            // a second frame complete finds nothing untagged and retires instead
            if ($urandom_range(0, 9) < 3)
               send_request(CMD_FRAME, $urandom, pick_align(), rand_fence(), done);
         end else begin
            r = $urandom_range(0, 99);
            send_request(logic'($urandom_range(0, 1)),
                         (r < 50) ? ADDR_W'($urandom) : pick_size(heap),
                         ALIGN_W'($urandom_range(0, 31)), rand_fence(), rand_fence());
         end
      end
   endtask

   initial begin
      sb                  = new();
      items_sent          = 0;
      calm_left           = 0;
      frame_tag           = '0;
      reset               = 1'b1;
      start               = 1'b0;
      req_command         = CMD_ALLOC;
      req_alloc_size      = '0;
      req_align_log2      = '0;
      req_frame_fence     = '0;
      req_completed_fence = '0;
      csr_valid           = 1'b0;
      csr_heap_bytes      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset heap size
      // frame complete on an empty ring
      send_request(CMD_FRAME, '0, '0, 48'd1, '0);
      // bad sizes: zero and one past the heap
      send_request(CMD_ALLOC, '0, '0, '0, '0);
      send_request(CMD_ALLOC, HEAP_RESET + 1'b1, '0, '0, '0);
      // empty ring places at 0, then a 64 KiB aligned range
      send_request(CMD_ALLOC, 32'd100, '0, '0, '0);
      send_request(CMD_ALLOC, 32'd1, ALIGN_W'(16), '0, '0);
      // huge alignment wraps to 0 and hits the untagged front
      send_request(CMD_ALLOC, 32'd100, ALIGN_W'(31), '0, '0);
      // zero fence tags, then counts as complete right away
      send_request(CMD_FRAME, '0, '0, '0, '0);
      send_request(CMD_ALLOC, 32'd4, ALIGN_W'(31), '0, '0);
      // largest fence, retired only once the completed fence reaches it
      send_request(CMD_FRAME, '0, '0, FENCE_MAX, '0);
      send_request(CMD_FRAME, '0, '0, 48'd1, FENCE_MAX - 1'b1);
      send_request(CMD_FRAME, '0, '0, 48'd1, FENCE_MAX);
      // fill every slot, then one more is refused as full
      repeat (RING_DEPTH + 1)
         send_request(CMD_ALLOC, FILL_BYTES, ALIGN_W'(12), '0, '0);

      // random part over a spread of heap sizes, extremes included
      run_phase(ADDR_W'($urandom_range(4096, 1 << 20)), 300);
      run_phase(32'd1, 200);
      run_phase('1, 300);
      run_phase('0, 20);
      run_phase(ADDR_W'($urandom_range(2, 300)), 250);
      run_phase(32'h8000_0000 | ADDR_W'($urandom), 280);
      run_phase(HEAP_RESET, 275);

      start = 1'b0;
      while (sb.expected_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
